>>> hdl/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;
    localparam int USIZE_W     = 9;
    localparam int COUNT_W     = 9;
    localparam int ELEM_W      = 8;
    localparam int UNIVERSE_RESET = 256;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_REMOVE = 3'd1,
        OP_TEST   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;    // take an input beat, read back index
        logic fetch;   // read dense entry and last member
        logic commit;  // update arrays and count, load result
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

>>> hdl/sse_ctrl.sv
`timescale 1ns / 1ps

module sse_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sse_pkg::status_t status,
    output sse_pkg::cmd_t    cmd
);

    sse_pkg::state_t state_reg;
    sse_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            sse_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sse_pkg::ST_READ;
                end
            end
            sse_pkg::ST_READ:
            begin
                cmd.fetch  = 1'b1;
                state_next = sse_pkg::ST_EXEC;
            end
            sse_pkg::ST_EXEC:
            begin
                // hold here until the result slot frees up
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = sse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sse_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sse_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/sse_datapath.sv
`timescale 1ns / 1ps

module sse_datapath
#(
    parameter int UNIVERSE_MAX = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sse_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sse_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sse_pkg::USIZE_W-1:0]         cfg_data,
    input  sse_pkg::cmd_t                       cmd,
    output sse_pkg::status_t                    status
);

    localparam int DEPTH = (UNIVERSE_MAX < 256) ? UNIVERSE_MAX : 256;
    localparam int AW    = $clog2(DEPTH);

    logic [sse_pkg::ELEM_W-1:0] dense_mem  [DEPTH];
    logic [AW-1:0]              sparse_mem [DEPTH];

    sse_pkg::op_t                 op_reg;
    logic [sse_pkg::ELEM_W-1:0]   elem_reg;
    logic [sse_pkg::ELEM_W-1:0]   pos_reg;
    logic                         err_reg;
    logic [AW-1:0]                bidx_reg;
    logic [sse_pkg::ELEM_W-1:0]   rd0_reg;
    logic [sse_pkg::ELEM_W-1:0]   rd1_reg;
    logic [sse_pkg::COUNT_W-1:0]  count_reg;
    logic [sse_pkg::COUNT_W-1:0]  count_next;
    logic [sse_pkg::USIZE_W-1:0]  usize_reg;
    logic                         out_valid_reg;
    logic [sse_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [sse_pkg::ELEM_W-1:0]   s_elem;
    logic                         s_err;
    logic [AW-1:0]                dense_raddr;
    logic [sse_pkg::COUNT_W-1:0]  count_m1;
    logic [sse_pkg::COUNT_W-1:0]  bidx_ext;
    logic                         is_elem_op;
    logic                         mem_ok;
    logic                         in_set;
    logic                         was_member;
    logic                         full;
    logic                         do_insert;
    logic                         do_remove;
    logic                         hole_moves;
    logic                         sparse_we;
    logic [AW-1:0]                sparse_waddr;
    logic [AW-1:0]                sparse_wdata;
    logic                         dense_we;
    logic [AW-1:0]                dense_waddr;
    logic [sse_pkg::ELEM_W-1:0]   dense_wdata;
    logic                         rd_valid;
    logic [sse_pkg::ELEM_W-1:0]   rd_value;
    logic                         err_out;

    assign s_elem = s_tdata[10:3];
    // bound is min(universe_size, UNIVERSE_MAX)
    assign s_err  = !(({1'b0, s_elem} < usize_reg)
                      && (32'(s_elem) < 32'(UNIVERSE_MAX)));

    assign count_m1    = count_reg - 9'd1;
    assign bidx_ext    = {{(sse_pkg::COUNT_W-AW){1'b0}}, bidx_reg};
    assign dense_raddr = (op_reg == sse_pkg::OP_READ) ? pos_reg[AW-1:0] : bidx_reg;

    assign is_elem_op = (op_reg == sse_pkg::OP_INSERT) || (op_reg == sse_pkg::OP_REMOVE)
                        || (op_reg == sse_pkg::OP_TEST);
    assign mem_ok     = is_elem_op && !err_reg;
    // member only if back index is live and the dense entry points back
    assign in_set     = (bidx_ext < count_reg) && (rd0_reg == elem_reg);
    assign was_member = mem_ok && in_set;
    assign full       = 32'(count_reg) >= 32'(UNIVERSE_MAX);
    assign do_insert  = cmd.commit && mem_ok && (op_reg == sse_pkg::OP_INSERT)
                        && !in_set && !full;
    assign do_remove  = cmd.commit && mem_ok && (op_reg == sse_pkg::OP_REMOVE) && in_set;
    assign hole_moves = bidx_ext != count_m1;

    always_comb
    begin
        sparse_we    = 1'b0;
        sparse_waddr = elem_reg[AW-1:0];
        sparse_wdata = count_reg[AW-1:0];
        dense_we     = 1'b0;
        dense_waddr  = count_reg[AW-1:0];
        dense_wdata  = elem_reg;
        count_next   = count_reg;
        if (do_insert)
        begin
            sparse_we  = 1'b1;
            dense_we   = 1'b1;
            count_next = count_reg + 9'd1;
        end
        else if (do_remove)
        begin
            count_next = count_m1;
            // last member fills the hole
            if (hole_moves)
            begin
                sparse_we    = 1'b1;
                sparse_waddr = rd1_reg[AW-1:0];
                sparse_wdata = bidx_reg;
                dense_we     = 1'b1;
                dense_waddr  = bidx_reg;
                dense_wdata  = rd1_reg;
            end
        end
        else if (cmd.commit && (op_reg == sse_pkg::OP_CLEAR))
        begin
            count_next = '0;
        end
    end

    assign rd_valid = (op_reg == sse_pkg::OP_READ) && ({1'b0, pos_reg} < count_reg);
    assign rd_value = rd_valid ? rd0_reg : '0;
    assign err_out  = is_elem_op && err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bidx_reg <= sparse_mem[s_elem[AW-1:0]];
        end
        if (cmd.fetch)
        begin
            rd0_reg <= dense_mem[dense_raddr];
            rd1_reg <= dense_mem[count_m1[AW-1:0]];
        end
        if (sparse_we)
        begin
            sparse_mem[sparse_waddr] <= sparse_wdata;
        end
        if (dense_we)
        begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= sse_pkg::op_t'(s_tdata[2:0]);
            elem_reg <= s_elem;
            pos_reg  <= s_tdata[18:11];
            err_reg  <= s_err;
        end
        if (cmd.commit)
        begin
            out_data_reg <= {4'd0, err_out, rd_valid, rd_value, count_next, was_member};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            usize_reg     <= sse_pkg::USIZE_W'(sse_pkg::UNIVERSE_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_valid)
            begin
                usize_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign cfg_ready       = 1'b1;

endmodule

>>> hdl/sparse_set_engine.sv
`timescale 1ns / 1ps

// sparse set engine: set of small integers kept as a dense member list,
// a back-index array and a member count, so no array ever needs clearing
// input beats (s_*): op insert, remove, test, clear all or read member at
// position; every beat gives exactly one result beat (m_*) with the prior
// membership, the count after the operation, the member read and flags
// an element not below the bound (min of universe_size and UNIVERSE_MAX)
// sets bound_error and changes nothing
// universe_size is to be written on the cfg channel only while no operation
// is in flight; the block itself does not enforce this. One operation at a
// time: a new beat is taken only after the last one has read the back-index
// memory, then the dense memory, and made its writes
// the result sits in an output register; while the receiver stalls, the next
// beat is still taken and read, and its update waits until the register frees
// reset clears the count to zero and sets universe_size to 256; memory
// contents are left as they are, no clearing pass is needed
module sparse_set_engine
#(
    parameter int UNIVERSE_MAX = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[2:0], element[10:3], position[18:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // was_member[0], member_count[9:1],
                                   // member_value[17:10], member_valid[18],
                                   // bound_error[19]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // universe_size
);

    sse_pkg::cmd_t    cmd;
    sse_pkg::status_t status;

    sse_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sse_datapath #(
        .UNIVERSE_MAX (UNIVERSE_MAX)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int SET_CAP   = 256;
    localparam int LONG_HOLD = 300;
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // result beat as laid out in m_tdata[19:0]
    typedef struct packed {
        logic       bound_error;
        logic       member_valid;
        logic [7:0] member_value;
        logic [8:0] member_count;
        logic       was_member;
    } set_result_t;

    typedef struct packed {
        bit          cfg_write;
        logic [8:0]  cfg_value;
        logic [2:0]  op;
        logic [7:0]  element;
        logic [7:0]  position;
        bit          typed;
        set_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // op[2:0], element[10:3], position[18:11]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // was_member[0], member_count[9:1], member_value[17:10],
                            // member_valid[18], bound_error[19]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;

    // mirror of the set
    logic [7:0]  dense_list [SET_CAP];
    logic [7:0]  back_idx [SET_CAP];
    logic [8:0]  n_members;
    logic [8:0]  universe_q;

    set_result_t expected_results [$];
    stim_row_t   dir_rows [$];
    set_result_t got;
    set_result_t want_r;
    int          fail_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_req = 1'b0;
    logic [7:0]  perm [SET_CAP];

    sparse_set_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic set_result_t apply_op(input logic [2:0] op, input logic [7:0] elem,
                                             input logic [7:0] pos);
        set_result_t r;
        logic [8:0]  bound;
        logic [7:0]  hole;
        logic [7:0]  last;
        bit          present;
        r = '0;
        bound = (universe_q < 9'(SET_CAP)) ? universe_q : 9'(SET_CAP);
        case (op)
            sse_pkg::OP_INSERT, sse_pkg::OP_REMOVE, sse_pkg::OP_TEST:
            begin
                if ({1'b0, elem} >= bound)
                begin
                    r.bound_error = 1'b1;
                end
                else
                begin
                    present = ({1'b0, back_idx[elem]} < n_members) &&
                              (dense_list[back_idx[elem]] == elem);
                    r.was_member = present;
                    if (op == sse_pkg::OP_INSERT && !present && n_members < 9'(SET_CAP))
                    begin
                        back_idx[elem] = n_members[7:0];
                        dense_list[n_members[7:0]] = elem;
                        n_members = n_members + 9'd1;
                    end
                    else if (op == sse_pkg::OP_REMOVE && present)
                    begin
                        // last member fills the hole
                        hole = back_idx[elem];
                        n_members = n_members - 9'd1;
                        if ({1'b0, hole} != n_members)
                        begin
                            last = dense_list[n_members[7:0]];
                            dense_list[hole] = last;
                            back_idx[last] = hole;
                        end
                    end
                end
            end
            sse_pkg::OP_CLEAR:
            begin
                n_members = '0;
            end
            sse_pkg::OP_READ:
            begin
                if ({1'b0, pos} < n_members)
                begin
                    r.member_valid = 1'b1;
                    r.member_value = dense_list[pos];
                end
            end
            default:
            begin
            end
        endcase
        r.member_count = n_members;
        return r;
    endfunction

    task automatic op_row(input logic [2:0] op, input logic [7:0] elem, input logic [7:0] pos);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.element = elem;
        row.position = pos;
        dir_rows.push_back(row);
    endtask

    task automatic known_row(input logic [2:0] op, input logic [7:0] elem, input logic [7:0] pos,
                             input logic was, input logic [8:0] cnt, input logic [7:0] val,
                             input logic valid, input logic err);
        stim_row_t row;
        row = '0;
        row.op = op;
        row.element = elem;
        row.position = pos;
        row.typed = 1'b1;
        row.want = {err, valid, val, cnt, was};
        dir_rows.push_back(row);
    endtask

    task automatic cfg_row(input logic [8:0] value);
        stim_row_t row;
        row = '0;
        row.cfg_write = 1'b1;
        row.cfg_value = value;
        dir_rows.push_back(row);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_universe(input logic [8:0] value);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        universe_q = value;
    endtask

    task automatic send_beat(input logic [2:0] op, input logic [7:0] elem, input logic [7:0] pos,
                             input bit typed, input set_result_t want);
        set_result_t predicted;
        predicted = apply_op(op, elem, pos);
        expected_results.push_back(typed ? want : predicted);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pos, elem, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic random_ops(input int n);
        int         pick;
        int         top;
        logic [2:0] op;
        logic [7:0] elem;
        logic [7:0] pos;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = sse_pkg::OP_INSERT;
            else if (pick < 60)
                op = sse_pkg::OP_REMOVE;
            else if (pick < 74)
                op = sse_pkg::OP_TEST;
            else if (pick < 90)
                op = sse_pkg::OP_READ;
            else if (pick < 93)
                op = sse_pkg::OP_CLEAR;
            else
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            // keep most elements near the bound so membership gets exercised
            top = universe_q + 2;
            if (top > 255)
                top = 255;
            if ($urandom_range(0, 3) != 0)
                elem = 8'($urandom_range(0, top));
            else
                elem = 8'($urandom_range(0, 255));
            top = n_members;
            if (top > 255)
                top = 255;
            if ($urandom_range(0, 3) != 0)
                pos = 8'($urandom_range(0, top));
            else
                pos = 8'($urandom_range(0, 255));
            send_beat(op, elem, pos, 1'b0, '0);
        end
    endtask

    // receiver: random stalls, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (idle_on ? $urandom_range(1, 30) : 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[19:0];
            if (expected_results.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result beat %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want_r = expected_results.pop_front();
                if (got.was_member !== want_r.was_member ||
                    got.member_count !== want_r.member_count ||
                    got.member_value !== want_r.member_value ||
                    got.member_valid !== want_r.member_valid ||
                    got.bound_error !== want_r.bound_error)
                begin
                    if (fail_count < 10)
                        $display({"mismatch: exp was=%0d cnt=%0d val=%0d valid=%0d err=%0d,",
                                  " got was=%0d cnt=%0d val=%0d valid=%0d err=%0d"},
                                 want_r.was_member, want_r.member_count, want_r.member_value,
                                 want_r.member_valid, want_r.bound_error,
                                 got.was_member, got.member_count, got.member_value,
                                 got.member_valid, got.bound_error);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] tmp;
        int         j;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        for (int i = 0; i < SET_CAP; i++)
        begin
            dense_list[i] = '0;
            back_idx[i]   = '0;
        end
        n_members  = '0;
        universe_q = 9'(sse_pkg::UNIVERSE_RESET);

        // directed table, starting with the universe at its reset value
        known_row(sse_pkg::OP_TEST,   8'd0,   8'd0,   1'b0, 9'd0, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 9'd0, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_INSERT, 8'd0,   8'd0,   1'b0, 9'd1, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_INSERT, 8'd255, 8'd0,   1'b0, 9'd2, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_INSERT, 8'd0,   8'd0,   1'b1, 9'd2, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_READ,   8'd0,   8'd1,   1'b0, 9'd2, 8'd255, 1'b1, 1'b0);
        known_row(sse_pkg::OP_READ,   8'd0,   8'd255, 1'b0, 9'd2, 8'd0,   1'b0, 1'b0);
        op_row(sse_pkg::OP_INSERT, 8'd170, 8'd0);
        op_row(sse_pkg::OP_REMOVE, 8'd0, 8'd0);        // last member moves into the hole
        op_row(sse_pkg::OP_READ, 8'd0, 8'd0);
        op_row(sse_pkg::OP_REMOVE, 8'd0, 8'd0);        // remove of a non-member
        op_row(sse_pkg::OP_REMOVE, 8'd255, 8'd0);      // removing the last slot itself
        op_row(OP_SPARE_LO, 8'd255, 8'd255);
        op_row(OP_SPARE_HI, 8'd85, 8'd85);
        op_row(sse_pkg::OP_INSERT, 8'd200, 8'd0);
        cfg_row(9'd100);                               // shrink below a member
        known_row(sse_pkg::OP_TEST,   8'd200, 8'd0,   1'b0, 9'd2, 8'd0,   1'b0, 1'b1);
        op_row(sse_pkg::OP_REMOVE, 8'd200, 8'd0);
        op_row(sse_pkg::OP_INSERT, 8'd100, 8'd0);
        op_row(sse_pkg::OP_INSERT, 8'd99, 8'd0);
        op_row(sse_pkg::OP_READ, 8'd0, 8'd1);          // shrunk-out member still listed
        cfg_row(9'd0);
        known_row(sse_pkg::OP_TEST,   8'd0,   8'd0,   1'b0, 9'd3, 8'd0,   1'b0, 1'b1);
        cfg_row(9'd511);                               // oversized bound clamps
        op_row(sse_pkg::OP_INSERT, 8'd255, 8'd0);
        op_row(sse_pkg::OP_TEST, 8'd254, 8'd0);
        known_row(sse_pkg::OP_CLEAR,  8'd0,   8'd0,   1'b0, 9'd0, 8'd0,   1'b0, 1'b0);
        known_row(sse_pkg::OP_TEST,   8'd170, 8'd0,   1'b0, 9'd0, 8'd0,   1'b0, 1'b0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].cfg_write)
                write_universe(dir_rows[i].cfg_value);
            else
                send_beat(dir_rows[i].op, dir_rows[i].element, dir_rows[i].position,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        // fill the whole universe in random order, with one long receiver hold
        write_universe(9'd256);
        send_beat(sse_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
        for (int i = 0; i < SET_CAP; i++)
            perm[i] = 8'(i);
        for (int i = SET_CAP - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < SET_CAP; i++)
        begin
            if (i == 64)
                hold_req = 1'b1;
            send_beat(sse_pkg::OP_INSERT, perm[i], 8'($urandom_range(0, 255)), 1'b0, '0);
        end
        send_beat(sse_pkg::OP_INSERT, perm[0], 8'd0, 1'b0, '0);
        send_beat(sse_pkg::OP_READ, 8'd0, 8'd255, 1'b0, '0);
        random_ops(40);

        write_universe(9'd1);
        random_ops(50);
        write_universe(9'd16);
        random_ops(60);
        write_universe(9'($urandom_range(2, 255)));
        random_ops(40);
        wait_drain();
        random_ops(40);
        write_universe(9'd511);
        random_ops(80);
        write_universe(9'd0);
        random_ops(20);
        write_universe(9'd300);
        random_ops(60);

        // closing stretch runs at full rate
        idle_on = 1'b0;
        write_universe(9'd256);
        random_ops(80);

        wait_drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
hdl/sse_pkg.sv
hdl/sse_ctrl.sv
hdl/sse_datapath.sv
hdl/sparse_set_engine.sv
tb/sv/tb.sv
